/* rtl/core/sqmm_pkg.sv */
// Shared types, constants and helpers of the square matrix multiplier.
package sqmm_pkg;

	localparam int MAX_SIZE_DEF   = 8;   // largest matrix edge supported
	localparam int QUEUE_DEPTH_DEF = 4;  // words buffered between front and back
	localparam int VAL_W  = 16;          // Q8.8 element
	localparam int PROD_W = 32;          // Q16.16 product
	localparam int ACC_W  = 40;          // Q24.16 sum
	localparam int IDX_W  = 3;           // row / column index
	localparam int ADDR_W = 6;           // element position within a matrix
	localparam int SIZE_W = 4;           // size register
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	// One loaded word, classified by the front end.
	typedef struct packed {
		logic signed [VAL_W-1:0]  a_value;
		logic signed [VAL_W-1:0]  b_value;
		logic [ADDR_W-1:0]        addr;   // row-major position
		logic                     done;   // final element of the matrix pair
		logic [SIZE_W-1:0]        size;   // effective edge length
	} front_word_t;

	// Control travelling alongside the multiply-accumulate pipeline.
	typedef struct packed {
		logic              valid;
		logic              first;  // first term of a dot product
		logic              lastk;  // final term of a dot product
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;   // final element of the result matrix
	} mac_ctl_t;

	typedef enum logic {
		BK_LOAD,
		BK_RUN
	} back_state_t;

	// Clamp the raw size register into 1..lim.
	function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] raw,
		input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] n;
		n = raw;
		if (raw == '0) begin
			n = 4'd1;
		end else if (raw > lim) begin
			n = lim;
		end
		return n;
	endfunction

endpackage

/* rtl/core/square_matrix_multiply.sv */
// Top level of the square matrix multiplier.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: a_value[15:0], b_value[31:16]
//   m_*      out  m_tvalid/m_tready  m_tdata: c_value[39:0]; m_tuser: row, col; m_tlast
//   cfg_*    in   cfg_we             cfg_wdata: matrix_size[3:0]
//
// Loading takes one word a cycle while the queue is not full; it lets the source
// run up to four words ahead while the back end is busy with the previous matrix.
// Each result is a dot product of n terms through the single multiply-accumulate
// unit (one store read pair per cycle unless the output stalls), which registers
// the store reads, the product and the sum in turn. Loading and computing
// alternate in the back end: no word is popped while a matrix is computing.
// Reset clears control only; the element stores need no clearing pass.
// A stalled output freezes the whole multiply-accumulate pipeline.
module square_matrix_multiply #(
	parameter int MAX_SIZE    = sqmm_pkg::MAX_SIZE_DEF,
	parameter int QUEUE_DEPTH = sqmm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,  // matrix_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // a_value[15:0], b_value[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // c_value[39:0]
	output logic [5:0]  m_tuser,    // row[2:0], col[5:3]
	output logic        m_tlast
);
	import sqmm_pkg::*;

	logic        push_valid, push_ready;
	front_word_t push_word;
	logic        q_valid, q_pop;
	front_word_t q_word;

	// Front: hold the size, tag each word with its position and matrix end.
	sqmm_front #(
		.MAX_SIZE (MAX_SIZE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	// Decouple: let the source run ahead while the back end computes.
	sqmm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_word   (q_word)
	);

	// Back: fill the stores, then sweep every dot product through one MAC.
	sqmm_back #(
		.MAX_SIZE (MAX_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_word   (q_word),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* rtl/core/sqmm_front.sv */
// Front end: accepts input words, holds the size register and tags each word.
module sqmm_front #(
	parameter int MAX_SIZE = sqmm_pkg::MAX_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sqmm_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,
	output logic                        push_valid,
	input  logic                        push_ready,
	output sqmm_pkg::front_word_t       push_word
);
	import sqmm_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] pos_q;
	logic [SIZE_W-1:0] n_eff;
	logic [7:0]        n_sq;
	logic [ADDR_W-1:0] total_m1;
	logic              at_end;
	logic              accept;

	assign n_eff    = effective_size(size_q, SIZE_W'(MAX_SIZE));
	assign n_sq     = {4'b0, n_eff} * {4'b0, n_eff};
	assign total_m1 = ADDR_W'(n_sq - 8'd1);
	assign at_end   = (pos_q == total_m1);

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;
	assign accept     = s_tvalid && push_ready;

	always_comb begin
		push_word.a_value = s_tdata[15:0];
		push_word.b_value = s_tdata[31:16];
		push_word.addr    = pos_q;
		push_word.done    = at_end;
		push_word.size    = n_eff;
	end

	// A size write drops any partly loaded matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			pos_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
			pos_q  <= '0;
		end else if (accept) begin
			pos_q <= at_end ? '0 : pos_q + 1'b1;
		end
	end

endmodule

/* rtl/core/sqmm_queue.sv */
// Short queue of classified words between front and back.
module sqmm_queue #(
	parameter int DEPTH = sqmm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  sqmm_pkg::front_word_t push_word,
	output logic                  pop_valid,
	input  logic                  pop,
	output sqmm_pkg::front_word_t pop_word
);
	import sqmm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	front_word_t      slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != (PW+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_word   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/sqmm_back.sv */
// Back end: element stores, multiply-accumulate sequencer and output register.
module sqmm_back #(
	parameter int MAX_SIZE = sqmm_pkg::MAX_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  sqmm_pkg::front_word_t q_word,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,
	output logic [5:0]            m_tuser,
	output logic                  m_tlast
);
	import sqmm_pkg::*;

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [VAL_W-1:0] mem_a [0:DEPTH-1];
	logic signed [VAL_W-1:0] mem_b [0:DEPTH-1];

	back_state_t state_q, state_d;

	logic [SIZE_W-1:0] n_q;
	logic [SIZE_W-1:0] n_m1;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [ADDR_W-1:0] abase_q, bptr_q, a_addr;
	logic              lastk, lastj, lasti, issue, adv, load_done;

	logic signed [VAL_W-1:0]  a_s1, b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	mac_ctl_t                 ctl_s1, ctl_s2;
	logic signed [ACC_W-1:0]  acc_q, sum;

	logic                     out_valid_q;
	logic signed [ACC_W-1:0]  c_q;
	logic [IDX_W-1:0]         row_q, col_q;
	logic                     last_q;

	assign n_m1      = n_q - 4'd1;
	assign lastk     = ({1'b0, k_q} == n_m1);
	assign lastj     = ({1'b0, j_q} == n_m1);
	assign lasti     = ({1'b0, i_q} == n_m1);
	assign a_addr    = abase_q + {3'b0, k_q};
	assign adv       = !out_valid_q || m_tready;
	assign issue     = (state_q == BK_RUN) && adv;
	assign q_pop     = (state_q == BK_LOAD) && q_valid;
	assign load_done = q_pop && q_word.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_LOAD: begin
				if (load_done) state_d = BK_RUN;
			end
			BK_RUN: begin
				if (issue && lastk && lastj && lasti) state_d = BK_LOAD;
			end
			default: state_d = BK_LOAD;
		endcase
	end

	// Store writes while loading, registered reads while running.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			mem_a[q_word.addr[AW-1:0]] <= q_word.a_value;
			mem_b[q_word.addr[AW-1:0]] <= q_word.b_value;
		end
		if (issue) begin
			a_s1 <= mem_a[a_addr[AW-1:0]];
			b_s1 <= mem_b[bptr_q[AW-1:0]];
		end
	end

	// Walk i, j, k; keep i*n and k*n+j as running addresses.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= SIZE_RESET;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			abase_q <= '0;
			bptr_q  <= '0;
		end else if (load_done) begin
			n_q     <= q_word.size;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			abase_q <= '0;
			bptr_q  <= '0;
		end else if (issue) begin
			if (lastk) begin
				k_q <= '0;
				if (lastj) begin
					j_q     <= '0;
					i_q     <= i_q + 1'b1;
					abase_q <= abase_q + {2'b0, n_q};
					bptr_q  <= '0;
				end else begin
					j_q    <= j_q + 1'b1;
					bptr_q <= {3'b0, j_q + 3'd1};
				end
			end else begin
				k_q    <= k_q + 1'b1;
				bptr_q <= bptr_q + {2'b0, n_q};
			end
		end
	end

	assign sum = (ctl_s2.first ? '0 : acc_q) + ACC_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			ctl_s1.valid <= issue;
			ctl_s1.first <= (k_q == '0);
			ctl_s1.lastk <= lastk;
			ctl_s1.row   <= i_q;
			ctl_s1.col   <= j_q;
			ctl_s1.last  <= lasti && lastj;
			ctl_s2       <= ctl_s1;
			out_valid_q  <= ctl_s2.valid && ctl_s2.lastk;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= a_s1 * b_s1;
			if (ctl_s2.valid) begin
				acc_q <= sum;
			end
			if (ctl_s2.valid && ctl_s2.lastk) begin
				c_q    <= sum;
				row_q  <= ctl_s2.row;
				col_q  <= ctl_s2.col;
				last_q <= ctl_s2.last;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = c_q;
	assign m_tuser  = {col_q, row_q};
	assign m_tlast  = last_q;

	a_pop_only_loading: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == BK_LOAD))
		else $error("queue popped while running");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> (({1'b0, k_q} < n_q) && ({1'b0, i_q} < n_q)
			&& ({1'b0, j_q} < n_q)))
		else $error("index beyond matrix size");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> (({2'b0, a_addr} < ({4'b0, n_q} * {4'b0, n_q}))
			&& ({2'b0, bptr_q} < ({4'b0, n_q} * {4'b0, n_q}))))
		else $error("store address beyond loaded matrix");

endmodule

/* tb/sv/square_matrix_multiply_tb.sv */
// Self-checking stream testbench for the square matrix multiplier.
`timescale 1ns / 100ps

module square_matrix_multiply_tb;

	import sqmm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest legal run
	localparam int SETTLE      = 40;      // queue drain plus pipeline, with margin
	localparam int STORE_DEPTH = MAX_SIZE_DEF * MAX_SIZE_DEF;
	localparam int PRINT_LIMIT = 20;

	// One element of the product matrix as the block should emit it.
	typedef struct {
		logic signed [ACC_W-1:0] c_value;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic                    last;
	} c_elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;    // a_value[15:0], b_value[31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // c_value[39:0]
	logic [5:0]  m_tuser;         // row[2:0], col[5:3]
	logic        m_tlast;

	// Mirror of the block: size register, element stores and load position.
	logic [SIZE_W-1:0]       size_reg = SIZE_RESET;
	logic signed [VAL_W-1:0] a_mem [STORE_DEPTH];
	logic signed [VAL_W-1:0] b_mem [STORE_DEPTH];
	int unsigned             loaded = 0;
	c_elem_t                 product_q [$];

	int unsigned words_sent = 0;
	int unsigned results_checked = 0;
	int unsigned matrices_checked = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;

	bit gaps_on = 1'b0;      // random idling on both sides
	int hold_req = 0;        // long receiver hold-off, in cycles, when set
	int hold_left = 0;
	int sink_stall = 0;

	square_matrix_multiply dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			return $urandom_range(1, 3);
		end else if (r < 9) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Random Q8.8 element, biased towards the extremes and zero.
	function automatic logic signed [VAL_W-1:0] rand_q88();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Edge length the block really uses: zero acts as one, large values clamp.
	function automatic int unsigned edge_len();
		if (size_reg == '0) begin
			return 1;
		end else if (size_reg > MAX_SIZE_DEF) begin
			return MAX_SIZE_DEF;
		end
		return size_reg;
	endfunction

	// Store one accepted pair; on the final pair of a matrix queue every C element.
	task automatic absorb_pair(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		int unsigned n;
		int unsigned pos;
		logic signed [ACC_W-1:0] acc;
		c_elem_t e;
		n = edge_len();
		pos = loaded % STORE_DEPTH;
		a_mem[pos] = a;
		b_mem[pos] = b;
		loaded = pos + 1;
		if (loaded >= n * n) begin
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					acc = '0;
					for (int k = 0; k < n; k++) begin
						acc += a_mem[i * n + k] * b_mem[k * n + j];
					end
					e.c_value = acc;
					e.row = IDX_W'(i);
					e.col = IDX_W'(j);
					e.last = (i == n - 1) && (j == n - 1);
					product_q.push_back(e);
				end
			end
			loaded = 0;
		end
	endtask

	task automatic report_mismatch(input string what);
		if (errors < PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		errors++;
	endtask

	// Offer one word; called and returning at a falling edge. Leave tvalid high
	// so back-to-back words keep the bus busy.
	task automatic send_pair(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = gap_len();
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		do begin
			@(posedge clk);
		end while (s_tready !== 1'b1);
		absorb_pair(a, b);
		words_sent++;
		@(negedge clk);
	endtask

	// Drop tvalid, wait for every expected element, then let the pipeline empty.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (product_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write the size register; any write restarts loading from position zero.
	task automatic write_size(input logic [SIZE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		size_reg = value;
		loaded = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_matrix(input int unsigned words);
		for (int p = 0; p < words; p++) begin
			send_pair(rand_q88(), rand_q88());
		end
	endtask

	// Receiver: random stalls, overridden by a long hold-off when one runs.
	always @(negedge clk) begin
		if (hold_left != 0 || sink_stall != 0) begin
			m_tready <= 1'b0;
			if (hold_left == 0) begin
				sink_stall <= sink_stall - 1;
			end
		end else begin
			m_tready <= 1'b1;
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				sink_stall <= gap_len();
			end
		end
	end

	// Count the hold-off down at rising edges, away from the falling-edge readers.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
		end
	end

	// Compare each accepted result word with the oldest expected element.
	always @(posedge clk) begin
		c_elem_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (product_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result c=%h row=%0d col=%0d",
					m_tdata, m_tuser[2:0], m_tuser[5:3]));
			end else begin
				want = product_q.pop_front();
				if (m_tdata !== want.c_value) begin
					report_mismatch($sformatf("C[%0d][%0d] value %h, want %h",
						want.row, want.col, m_tdata, want.c_value));
				end
				if (m_tuser[2:0] !== want.row) begin
					report_mismatch($sformatf("row %0d, want %0d", m_tuser[2:0], want.row));
				end
				if (m_tuser[5:3] !== want.col) begin
					report_mismatch($sformatf("col %0d, want %0d", m_tuser[5:3], want.col));
				end
				if (m_tlast !== want.last) begin
					report_mismatch($sformatf("C[%0d][%0d] tlast %b, want %b",
						want.row, want.col, m_tlast, want.last));
				end
				if (want.last) begin
					matrices_checked++;
				end
				results_checked++;
			end
		end
	end

	// Reset size is eight: an 8x8 pair of near full-scale elements gives the
	// largest sums, well past 32 bits.
	task automatic test_reset_size();
		gaps_on = 1'b0;
		for (int p = 0; p < 64; p++) begin
			send_pair(16'sh8000, (p % 3 == 0) ? 16'sh7fff : 16'sh8000);
		end
		wait_drain();
	endtask

	// One-element matrices with every sign combination of the extremes, then a 2x2 of minima.
	task automatic test_extremes();
		gaps_on = 1'b1;
		write_size(4'd1);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'shffff, 16'sh0001);
		wait_drain();
		write_size(4'd2);
		repeat (4) send_pair(16'sh8000, 16'sh8000);
		wait_drain();
	endtask

	// A size of zero acts as a single element.
	task automatic test_zero_size();
		write_size(4'd0);
		send_pair(16'sh8000, 16'sh7fff);
		wait_drain();
	endtask

	// Discard a half-loaded matrix by rewriting the size, then load a fresh one.
	task automatic test_resize_midload();
		write_size(4'd3);
		for (int p = 0; p < 5; p++) begin
			send_pair(rand_q88(), rand_q88());
		end
		wait_drain();
		write_size(4'd2);
		send_random_matrix(4);
		wait_drain();
	endtask

	// Hold the receiver off while the source keeps offering small matrices,
	// so the queue fills and tready drops at the input.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		write_size(4'd2);
		hold_req = 300;
		send_random_matrix(48);
		wait_drain();
	endtask

	// Size fields above the maximum clamp to eight.
	task automatic test_above_max();
		gaps_on = 1'b1;
		write_size(4'd15);
		send_random_matrix(64);
		wait_drain();
	endtask

	// Random contents over a spread of sizes, with and without idling; now and
	// then break a matrix off part-way and restart it.
	task automatic test_random_sizes();
		int unsigned size_plan [7] = '{1, 2, 3, 4, 5, 7, 0};
		int unsigned count_plan [7] = '{3, 3, 2, 2, 1, 1, 2};
		int unsigned n;
		for (int s = 0; s < 7; s++) begin
			gaps_on = ($urandom_range(0, 2) != 0);
			write_size(SIZE_W'(size_plan[s]));
			n = edge_len();
			if (n > 1 && $urandom_range(0, 2) == 0) begin
				send_random_matrix($urandom_range(1, n * n - 1));
				wait_drain();
				write_size(SIZE_W'(size_plan[s]));
			end
			for (int m = 0; m < count_plan[s]; m++) begin
				send_random_matrix(n * n);
			end
			wait_drain();
		end
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL square_matrix_multiply");
		$finish;
	end

	initial begin : main
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_size();
		test_extremes();
		test_zero_size();
		test_resize_midload();
		test_random_sizes();
		test_backpressure();
		test_above_max();
		wait_drain();
		$display("Sent %0d element pairs; checked %0d products over %0d matrices.",
			words_sent, results_checked, matrices_checked);
		$display("Sizes 0 to 15 incl. clamping, mid-load resize, long output hold-off.");
		if (errors == 0 && product_q.size() == 0) begin
			$display("PASS square_matrix_multiply");
		end else begin
			$display("%0d mismatches, %0d products never seen", errors, product_q.size());
			$display("FAIL square_matrix_multiply");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/sqmm_pkg.sv
rtl/core/sqmm_front.sv
rtl/core/sqmm_queue.sv
rtl/core/sqmm_back.sv
rtl/core/square_matrix_multiply.sv
tb/sv/square_matrix_multiply_tb.sv
